// ===== design/efp_pkg.sv =====
// Shared types and constants of the escape-time fractal pixel block.
`default_nettype none
package efp_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ITERATION_LIMIT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_X_SPAN          = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_SPAN          = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_X_OFFSET        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_OFFSET        = 3'd5;

  localparam int PIX_W      = 16;
  localparam int CNT_W      = 16;
  localparam int SPAN_W     = 32;
  localparam int SPAN_FRAC  = 28;
  localparam int LOG_G      = 16;
  localparam int LOG_MANT   = 30;
  localparam int MOD_W      = 20;
  localparam int CHAN_W     = 8;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_X,
    F_MUL_X,
    F_DIV_Y,
    F_MUL_Y,
    F_PUSH
  } efp_front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQX,
    B_SQY,
    B_TEST,
    B_XY,
    B_SCAN,
    B_LOG,
    B_MOD,
    B_OUT
  } efp_back_state_t;

  typedef struct packed {
    logic              escaped;
    logic [CHAN_W-1:0] channel_a;
    logic [CHAN_W-1:0] channel_b;
    logic [CHAN_W-1:0] channel_c;
    logic [CNT_W-1:0]  escape_count;
  } efp_result_t;

endpackage
`default_nettype wire

// ===== design/efp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module efp_div #(
  parameter int W  = 46,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [W-1:0]       quot,
  output logic [DW-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW:0]   rs;
  logic [DW:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    rs       = {r_r, q_r[W-1]};
    diff     = rs - {1'b0, d_r};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        r_nxt = diff[DW-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = rs[DW-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

// ===== design/efp_mul.sv =====
// Signed saturating fixed-point multiplier built from four half-width partial products.
`default_nettype none
module efp_mul #(
  parameter int FRAC_BITS = 30,
  parameter int INT_BITS  = 18
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire logic                                   coord_scale,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0]   a,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0]   b,
  output logic                                        done,
  output logic signed [INT_BITS+FRAC_BITS-1:0]        p
);
  localparam int QB = INT_BITS + FRAC_BITS;
  localparam int H  = (QB + 1) / 2;
  localparam int AW = 4 * H;
  localparam int SW = $clog2(AW);
  localparam logic [QB-1:0] QMAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] QMIN = {1'b1, {(QB-1){1'b0}}};

  logic          busy_r;
  logic          done_r;
  logic [2:0]    cnt_r;
  logic          pp_valid_r;
  logic [2*H-1:0] ma_r, mb_r;
  logic          neg_r;
  logic [SW-1:0] sh_r;
  logic [2*H-1:0] pp_r;
  logic [1:0]    ppsel_r;
  logic [AW-1:0] acc_r;
  logic [QB-1:0] p_r;

  logic [QB-1:0] abs_a, abs_b;
  logic [H-1:0]  ah, bh;
  logic [AW-1:0] pp_shift;
  logic [AW-1:0] m;
  logic          sat;
  logic [QB-1:0] res;

  always_comb begin
    abs_a = a[QB-1] ? QB'(-a) : QB'(a);
    abs_b = b[QB-1] ? QB'(-b) : QB'(b);
    ah    = cnt_r[1] ? ma_r[2*H-1:H] : ma_r[H-1:0];
    bh    = cnt_r[0] ? mb_r[2*H-1:H] : mb_r[H-1:0];
    case (ppsel_r)
      2'd0:    pp_shift = AW'(pp_r);
      2'd1:    pp_shift = AW'(pp_r) << H;
      default: pp_shift = AW'(pp_r) << (2 * H);
    endcase
    m   = acc_r >> sh_r;
    sat = |m[AW-1:QB-1];
    if (sat) begin
      res = neg_r ? QMIN : QMAX;
    end else begin
      res = neg_r ? QB'(-m[QB-1:0]) : m[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      cnt_r      <= '0;
      pp_valid_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r     <= 1'b1;
        cnt_r      <= '0;
        pp_valid_r <= 1'b0;
      end else if (busy_r) begin
        pp_valid_r <= (cnt_r <= 3'd3);
        cnt_r      <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      ma_r  <= (2*H)'(abs_a);
      mb_r  <= (2*H)'(abs_b);
      neg_r <= a[QB-1] ^ b[QB-1];
      sh_r  <= coord_scale ? SW'(efp_pkg::SPAN_FRAC) : SW'(FRAC_BITS);
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r    <= ah * bh;
      ppsel_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
      if (pp_valid_r) begin
        acc_r <= acc_r + pp_shift;
      end
      if (cnt_r == 3'd5) begin
        p_r <= res;
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule
`default_nettype wire

// ===== design/efp_fifo.sv =====
// Small queue of mapped points between the front and back parts.
`default_nettype none
module efp_fifo #(
  parameter int W     = 96,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] data_r [DEPTH];
  logic [AW:0]  wr_r, rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= wr_r + (AW+1)'(1);
      end
      if (pop && !empty) begin
        rd_r <= rd_r + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      data_r[wr_r[AW-1:0]] <= din;
    end
  end

  assign empty = (wr_r == rd_r);
  assign full  = (wr_r[AW] != rd_r[AW]) && (wr_r[AW-1:0] == rd_r[AW-1:0]);
  assign dout  = data_r[rd_r[AW-1:0]];
endmodule
`default_nettype wire

// ===== design/efp_front.sv =====
// Front part: accepts pixels and maps them to points of the complex plane.
`default_nettype none
module efp_front #(
  parameter int FRAC_BITS = 30,
  parameter int INT_BITS  = 18
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_push,
  input  wire logic [efp_pkg::PIX_W-1:0]            in_pixel_x,
  input  wire logic [efp_pkg::PIX_W-1:0]            in_pixel_y,
  output logic                                      in_full,
  input  wire logic [efp_pkg::PIX_W-1:0]            image_width,
  input  wire logic signed [efp_pkg::SPAN_W-1:0]    x_span,
  input  wire logic signed [efp_pkg::SPAN_W-1:0]    y_span,
  input  wire logic signed [efp_pkg::SPAN_W-1:0]    x_offset,
  input  wire logic signed [efp_pkg::SPAN_W-1:0]    y_offset,
  output logic                                      fifo_push,
  output logic signed [INT_BITS+FRAC_BITS-1:0]      fifo_cx,
  output logic signed [INT_BITS+FRAC_BITS-1:0]      fifo_cy,
  input  wire logic                                 fifo_full
);
  localparam int QB    = INT_BITS + FRAC_BITS;
  localparam int DVW   = efp_pkg::PIX_W + FRAC_BITS;
  localparam int OSH_L = (FRAC_BITS >= efp_pkg::SPAN_FRAC) ? FRAC_BITS - efp_pkg::SPAN_FRAC : 0;
  localparam int OSH_R = (FRAC_BITS < efp_pkg::SPAN_FRAC) ? efp_pkg::SPAN_FRAC - FRAC_BITS : 0;
  localparam logic [QB-1:0] QMAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] QMIN = {1'b1, {(QB-1){1'b0}}};

  efp_pkg::efp_front_state_t state_r, state_nxt;
  logic                      kick_r, kick_nxt;
  logic [efp_pkg::PIX_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [QB-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;

  logic                      div_start, div_done;
  logic [DVW-1:0]            div_dividend, div_quot;
  logic [efp_pkg::PIX_W-1:0] div_divisor, div_rem;
  logic                      mul_start, mul_done;
  logic signed [QB-1:0]      mul_a, mul_b, mul_p;
  logic signed [QB-1:0]      noff_x, noff_y;

  function automatic logic signed [QB-1:0] sat_add(input logic signed [QB-1:0] x,
                                                   input logic signed [QB-1:0] y);
    logic [QB:0] s;
    s = {x[QB-1], x} + {y[QB-1], y};
    if (s[QB] != s[QB-1]) begin
      return s[QB] ? QMIN : QMAX;
    end
    return s[QB-1:0];
  endfunction

  function automatic logic signed [QB-1:0] neg_offset(input logic signed [31:0] v);
    logic [31:0]   om;
    logic [QB-1:0] sc;
    om = v[31] ? 32'(-v) : 32'(v);
    sc = (QB'(om) << OSH_L) >> OSH_R;
    return v[31] ? sc : QB'(-sc);
  endfunction

  efp_div #(.W(DVW), .DW(efp_pkg::PIX_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  efp_mul #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mul_start),
    .coord_scale (1'b1),
    .a           (mul_a),
    .b           (mul_b),
    .done        (mul_done),
    .p           (mul_p)
  );

  always_comb begin
    noff_x       = neg_offset(x_offset);
    noff_y       = neg_offset(y_offset);
    div_divisor  = (image_width == '0) ? efp_pkg::PIX_W'(1) : image_width;
    div_dividend = {(state_r == efp_pkg::F_DIV_Y) ? py_r : px_r, {FRAC_BITS{1'b0}}};
    div_start    = kick_r && (state_r == efp_pkg::F_DIV_X || state_r == efp_pkg::F_DIV_Y);
    mul_a        = {{(QB-DVW){1'b0}}, div_quot};
    mul_b        = (state_r == efp_pkg::F_MUL_Y)
                   ? {{(QB-efp_pkg::SPAN_W){y_span[31]}}, y_span}
                   : {{(QB-efp_pkg::SPAN_W){x_span[31]}}, x_span};
    mul_start    = kick_r && (state_r == efp_pkg::F_MUL_X || state_r == efp_pkg::F_MUL_Y);

    state_nxt = state_r;
    kick_nxt  = 1'b0;
    px_nxt    = px_r;
    py_nxt    = py_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    fifo_push = 1'b0;
    unique case (state_r)
      efp_pkg::F_IDLE: begin
        if (in_push) begin
          px_nxt    = in_pixel_x;
          py_nxt    = in_pixel_y;
          state_nxt = efp_pkg::F_DIV_X;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::F_DIV_X: begin
        if (div_done) begin
          state_nxt = efp_pkg::F_MUL_X;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::F_MUL_X: begin
        if (mul_done) begin
          cx_nxt    = sat_add(mul_p, noff_x);
          state_nxt = efp_pkg::F_DIV_Y;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::F_DIV_Y: begin
        if (div_done) begin
          state_nxt = efp_pkg::F_MUL_Y;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::F_MUL_Y: begin
        if (mul_done) begin
          cy_nxt    = sat_add(mul_p, noff_y);
          state_nxt = efp_pkg::F_PUSH;
        end
      end
      efp_pkg::F_PUSH: begin
        if (!fifo_full) begin
          fifo_push = 1'b1;
          state_nxt = efp_pkg::F_IDLE;
        end
      end
      default: state_nxt = efp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efp_pkg::F_IDLE;
      kick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= kick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
  end

  assign in_full = (state_r != efp_pkg::F_IDLE);
  assign fifo_cx = cx_r;
  assign fifo_cy = cy_r;
endmodule
`default_nettype wire

// ===== design/efp_back.sv =====
// Back part: iterates the orbit, takes the smooth count and the color channels.
`default_nettype none
module efp_back #(
  parameter int FRAC_BITS      = 30,
  parameter int INT_BITS       = 18,
  parameter int LOG_TABLE_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                fifo_empty,
  output logic                                     fifo_pop,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0] fifo_cx,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0] fifo_cy,
  input  wire logic [efp_pkg::CNT_W-1:0]           iteration_limit,
  output efp_pkg::efp_result_t                     res,
  output logic                                     res_valid,
  input  wire logic                                res_pop
);
  localparam int QB  = INT_BITS + FRAC_BITS;
  localparam int PW  = $clog2(QB);
  localparam int LGW = efp_pkg::LOG_G + $clog2(INT_BITS);
  localparam int LTB = LOG_TABLE_BITS;
  localparam int MW  = efp_pkg::LOG_MANT;
  localparam int GW  = efp_pkg::LOG_G;
  localparam int FLW = efp_pkg::CNT_W + 1;
  localparam int TW  = efp_pkg::CNT_W + 2;
  localparam logic [QB-1:0] QMAX   = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] QMIN   = {1'b1, {(QB-1){1'b0}}};
  localparam logic [QB-1:0] THRESH = QB'(1) << (efp_pkg::LOG_G + FRAC_BITS);

  efp_pkg::efp_back_state_t state_r, state_nxt;
  logic                      kick_r, kick_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [QB-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [QB-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic signed [QB-1:0]      x2_r, x2_nxt, y2_r, y2_nxt;
  logic [efp_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [QB-1:0]             sv_r, sv_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic                      pass_r, pass_nxt;
  logic [MW:0]               lx_r, lx_nxt;
  logic [GW-1:0]             ly_r, ly_nxt;
  logic [3:0]                round_r, round_nxt;
  logic [FLW-1:0]            fl_r, fl_nxt;
  logic [1:0]                k_r, k_nxt;
  efp_pkg::efp_result_t      work_r, work_nxt, out_r, out_nxt;

  logic                      mul_start, mul_done;
  logic signed [QB-1:0]      mul_a, mul_b, mul_p;
  logic                      div_start, div_done;
  logic [efp_pkg::MOD_W-1:0] div_dividend, div_quot;
  logic [efp_pkg::CNT_W-1:0] div_rem;

  logic [QB-1:0]             mag;
  logic [2*MW+1:0]           sq;
  logic [MW+1:0]             sq_top;
  logic [GW-1:0]             ly_n;
  logic [MW:0]               lx_n;
  logic [PW-1:0]             pf;
  logic [LGW-1:0]            lg;
  logic [TW-1:0]             tval;

  function automatic logic signed [QB-1:0] sat_add(input logic signed [QB-1:0] a,
                                                   input logic signed [QB-1:0] b);
    logic [QB:0] s;
    s = {a[QB-1], a} + {b[QB-1], b};
    if (s[QB] != s[QB-1]) begin
      return s[QB] ? QMIN : QMAX;
    end
    return s[QB-1:0];
  endfunction

  efp_mul #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mul_start),
    .coord_scale (1'b0),
    .a           (mul_a),
    .b           (mul_b),
    .done        (mul_done),
    .p           (mul_p)
  );

  efp_div #(.W(efp_pkg::MOD_W), .DW(efp_pkg::CNT_W)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (iteration_limit),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    mag    = x2_r + y2_r;
    sq     = lx_r * lx_r;
    sq_top = sq[2*MW+1:MW];
    ly_n   = {ly_r[GW-2:0], sq_top[MW+1]};
    lx_n   = sq_top[MW+1] ? sq_top[MW+1:1] : sq_top[MW:0];
    pf     = pos_r - PW'(FRAC_BITS);
    lg     = {pf[LGW-GW-1:0], ly_n};
    tval   = TW'(n_r) + TW'(GW + 2) - TW'(pos_r) - TW'(ly_n != '0);

    mul_a     = (state_r == efp_pkg::B_SQY) ? y_r : x_r;
    mul_b     = (state_r == efp_pkg::B_SQX) ? x_r : y_r;
    mul_start = kick_r && (state_r == efp_pkg::B_SQX || state_r == efp_pkg::B_SQY ||
                           state_r == efp_pkg::B_XY);
    div_start = kick_r && (state_r == efp_pkg::B_MOD);
    case (k_r)
      2'd0:    div_dividend = efp_pkg::MOD_W'({fl_r, 1'b0});
      2'd1:    div_dividend = efp_pkg::MOD_W'({fl_r, 2'b00});
      default: div_dividend = efp_pkg::MOD_W'({fl_r, 2'b00}) + efp_pkg::MOD_W'({fl_r, 1'b0});
    endcase

    state_nxt     = state_r;
    kick_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    n_nxt         = n_r;
    sv_nxt        = sv_r;
    pos_nxt       = pos_r;
    pass_nxt      = pass_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    round_nxt     = round_r;
    fl_nxt        = fl_r;
    k_nxt         = k_r;
    work_nxt      = work_r;
    out_nxt       = out_r;
    fifo_pop      = 1'b0;

    if (res_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      efp_pkg::B_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop  = 1'b1;
          cx_nxt    = fifo_cx;
          cy_nxt    = fifo_cy;
          x_nxt     = '0;
          y_nxt     = '0;
          n_nxt     = '0;
          state_nxt = efp_pkg::B_SQX;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::B_SQX: begin
        if (mul_done) begin
          x2_nxt    = mul_p;
          state_nxt = efp_pkg::B_SQY;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::B_SQY: begin
        if (mul_done) begin
          y2_nxt    = mul_p;
          state_nxt = efp_pkg::B_TEST;
        end
      end
      efp_pkg::B_TEST: begin
        work_nxt.escape_count = n_r;
        if (n_r >= iteration_limit) begin
          work_nxt.escaped   = 1'b0;
          work_nxt.channel_a = '0;
          work_nxt.channel_b = '0;
          work_nxt.channel_c = '0;
          state_nxt          = efp_pkg::B_OUT;
        end else if (mag >= THRESH) begin
          work_nxt.escaped = 1'b1;
          sv_nxt           = mag;
          pos_nxt          = PW'(QB - 1);
          pass_nxt         = 1'b0;
          state_nxt        = efp_pkg::B_SCAN;
        end else begin
          state_nxt = efp_pkg::B_XY;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::B_XY: begin
        if (mul_done) begin
          x_nxt     = sat_add(sat_add(x2_r, QB'(-y2_r)), cx_r);
          y_nxt     = sat_add(sat_add(mul_p, mul_p), cy_r);
          n_nxt     = n_r + efp_pkg::CNT_W'(1);
          state_nxt = efp_pkg::B_SQX;
          kick_nxt  = 1'b1;
        end
      end
      efp_pkg::B_SCAN: begin
        if (sv_r[QB-1]) begin
          lx_nxt    = {1'b1, sv_r[QB-2 -: LTB], {(MW-LTB){1'b0}}};
          ly_nxt    = '0;
          round_nxt = '0;
          state_nxt = efp_pkg::B_LOG;
        end else begin
          sv_nxt  = {sv_r[QB-2:0], 1'b0};
          pos_nxt = pos_r - PW'(1);
        end
      end
      efp_pkg::B_LOG: begin
        lx_nxt    = lx_n;
        ly_nxt    = ly_n;
        round_nxt = round_r + 4'd1;
        if (round_r == 4'(GW - 1)) begin
          if (!pass_r) begin
            sv_nxt    = {lg, {(QB-LGW){1'b0}}};
            pos_nxt   = PW'(LGW - 1);
            pass_nxt  = 1'b1;
            state_nxt = efp_pkg::B_SCAN;
          end else begin
            fl_nxt    = tval[TW-1] ? '0 : tval[FLW-1:0];
            k_nxt     = '0;
            state_nxt = efp_pkg::B_MOD;
            kick_nxt  = 1'b1;
          end
        end
      end
      efp_pkg::B_MOD: begin
        if (div_done) begin
          case (k_r)
            2'd0:    work_nxt.channel_a = div_rem[efp_pkg::CHAN_W-1:0];
            2'd1:    work_nxt.channel_b = div_rem[efp_pkg::CHAN_W-1:0];
            default: work_nxt.channel_c = div_rem[efp_pkg::CHAN_W-1:0];
          endcase
          if (k_r == 2'd2) begin
            state_nxt = efp_pkg::B_OUT;
          end else begin
            k_nxt    = k_r + 2'd1;
            kick_nxt = 1'b1;
          end
        end
      end
      efp_pkg::B_OUT: begin
        if (!out_valid_r) begin
          out_nxt       = work_r;
          out_valid_nxt = 1'b1;
          state_nxt     = efp_pkg::B_IDLE;
        end
      end
      default: state_nxt = efp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efp_pkg::B_IDLE;
      kick_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kick_r      <= kick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    x2_r    <= x2_nxt;
    y2_r    <= y2_nxt;
    n_r     <= n_nxt;
    sv_r    <= sv_nxt;
    pos_r   <= pos_nxt;
    pass_r  <= pass_nxt;
    lx_r    <= lx_nxt;
    ly_r    <= ly_nxt;
    round_r <= round_nxt;
    fl_r    <= fl_nxt;
    k_r     <= k_nxt;
    work_r  <= work_nxt;
    out_r   <= out_nxt;
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;
endmodule
`default_nettype wire

// ===== design/escape_time_fractal_pixel_top.sv =====
// Top level of the escape-time fractal pixel block.
`default_nettype none
// Each pixel is mapped to a point c by a serial divider and a multiplier, both used for
// the two coordinates in turn in the front part, then queued two deep for the back part.
// The back part iterates z = z*z + c with one multiplier that takes three products per
// iteration; an escaped point then takes a tail of leading-one searches, two logarithms,
// three modulo divisions and a load of the result. The back multiplier sets the rate.
// One result register holds the finished word until it is popped, while the front keeps
// accepting pixels until the queue is full.
module escape_time_fractal_pixel_top #(
  parameter int FRAC_BITS      = 30,
  parameter int INT_BITS       = 18,
  parameter int LOG_TABLE_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [efp_pkg::PIX_W-1:0]        in_pixel_x,
  input  wire logic [efp_pkg::PIX_W-1:0]        in_pixel_y,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic                                  out_escaped,
  output logic [efp_pkg::CHAN_W-1:0]            out_channel_a,
  output logic [efp_pkg::CHAN_W-1:0]            out_channel_b,
  output logic [efp_pkg::CHAN_W-1:0]            out_channel_c,
  output logic [efp_pkg::CNT_W-1:0]             out_escape_count,
  input  wire logic                             cfg_we,
  input  wire logic [efp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [efp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  localparam int QB = INT_BITS + FRAC_BITS;

  logic [efp_pkg::PIX_W-1:0]         image_width_r;
  logic [efp_pkg::CNT_W-1:0]         iteration_limit_r;
  logic signed [efp_pkg::SPAN_W-1:0] x_span_r, y_span_r, x_offset_r, y_offset_r;

  logic                 fifo_push, fifo_full, fifo_pop, fifo_empty;
  logic signed [QB-1:0] f_cx, f_cy, b_cx, b_cy;
  logic [2*QB-1:0]      fifo_dout;
  efp_pkg::efp_result_t res;
  logic                 res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= 16'd640;
      iteration_limit_r <= 16'd256;
      x_span_r          <= 32'sd872415232;
      y_span_r          <= 32'sd671088640;
      x_offset_r        <= 32'sd536870912;
      y_offset_r        <= 32'sd335544320;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        efp_pkg::CFG_IMAGE_WIDTH:     image_width_r     <= cfg_wdata[efp_pkg::PIX_W-1:0];
        efp_pkg::CFG_ITERATION_LIMIT: iteration_limit_r <= cfg_wdata[efp_pkg::CNT_W-1:0];
        efp_pkg::CFG_X_SPAN:          x_span_r          <= cfg_wdata;
        efp_pkg::CFG_Y_SPAN:          y_span_r          <= cfg_wdata;
        efp_pkg::CFG_X_OFFSET:        x_offset_r        <= cfg_wdata;
        efp_pkg::CFG_Y_OFFSET:        y_offset_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  efp_front #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .in_full     (in_full),
    .image_width (image_width_r),
    .x_span      (x_span_r),
    .y_span      (y_span_r),
    .x_offset    (x_offset_r),
    .y_offset    (y_offset_r),
    .fifo_push   (fifo_push),
    .fifo_cx     (f_cx),
    .fifo_cy     (f_cy),
    .fifo_full   (fifo_full)
  );

  efp_fifo #(.W(2 * QB), .DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .din   ({f_cx, f_cy}),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .dout  (fifo_dout),
    .empty (fifo_empty)
  );

  assign b_cx = fifo_dout[2*QB-1:QB];
  assign b_cy = fifo_dout[QB-1:0];

  efp_back #(
    .FRAC_BITS      (FRAC_BITS),
    .INT_BITS       (INT_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (fifo_empty),
    .fifo_pop        (fifo_pop),
    .fifo_cx         (b_cx),
    .fifo_cy         (b_cy),
    .iteration_limit (iteration_limit_r),
    .res             (res),
    .res_valid       (res_valid),
    .res_pop         (out_pop)
  );

  assign out_empty        = !res_valid;
  assign out_escaped      = res.escaped;
  assign out_channel_a    = res.channel_a;
  assign out_channel_b    = res.channel_b;
  assign out_channel_c    = res.channel_c;
  assign out_escape_count = res.escape_count;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("point pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("point popped from an empty queue");

  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_escaped) |->
      (out_channel_a == '0 && out_channel_b == '0 && out_channel_c == '0))
    else $error("inside point with nonzero color channels");
endmodule
`default_nettype wire
